@@ rtl/ple_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, constants and helpers of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;
    localparam int SCAN_LANES     = 8;
    localparam int LANE_W         = 3;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_SHIFT_UP   = 2'd2,
        CELL_SHIFT_DOWN = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

    function automatic logic [LANE_W-1:0] first_one(input logic [SCAN_LANES-1:0] v);
        logic [LANE_W-1:0] idx;
        idx = '0;
        for (int i = SCAN_LANES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = LANE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/ple_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an item, loads, or takes a neighbor's item.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int ITEM_WIDTH = ple_pkg::ITEM_WIDTH_DEF
) (
    input  logic                  aclk,
    input  ple_pkg::cell_op_t     op,
    input  logic [ITEM_WIDTH-1:0] item_in,
    input  logic [ITEM_WIDTH-1:0] left_item,
    input  logic [ITEM_WIDTH-1:0] right_item,
    input  logic [ITEM_WIDTH-1:0] key,
    output logic [ITEM_WIDTH-1:0] item_q,
    output logic                  match
);

    logic [ITEM_WIDTH-1:0] item_reg;
    logic [ITEM_WIDTH-1:0] item_next;

    always_comb begin
        unique case (op)
            ple_pkg::CELL_HOLD:       item_next = item_reg;
            ple_pkg::CELL_LOAD:       item_next = item_in;
            ple_pkg::CELL_SHIFT_UP:   item_next = left_item;
            ple_pkg::CELL_SHIFT_DOWN: item_next = right_item;
            default:                  item_next = item_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_q = item_reg;
    assign match  = (item_reg == key);

endmodule

@@ rtl/ple_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_scan
// First-match search over the captured match vector, one lane group a cycle.
// ----------------------------------------------------------------------------
module ple_scan #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DEPTH-1:0]      match_in,
    output ple_pkg::scan_stat_t   stat,
    output logic [IDX_W-1:0]      index
);

    localparam int LANES  = ple_pkg::SCAN_LANES;
    localparam int NCHUNK = (DEPTH + LANES - 1) / LANES;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int VEC_W  = NCHUNK * LANES;

    logic [VEC_W-1:0]          vec_reg;
    logic [VEC_W-1:0]          vec_next;
    logic [CH_W-1:0]           chunk_reg;
    logic [CH_W-1:0]           chunk_next;
    logic                      run_reg;
    logic                      run_next;
    logic [LANES-1:0]          window;
    logic                      any_hit;
    logic                      last_chunk;
    logic [ple_pkg::LANE_W-1:0] lane;
    logic [CH_W+ple_pkg::LANE_W-1:0] idx_wide;

    assign window     = vec_reg[chunk_reg*LANES +: LANES];
    assign any_hit    = |window;
    assign last_chunk = (chunk_reg == CH_W'(NCHUNK - 1));
    assign lane       = ple_pkg::first_one(window);
    assign idx_wide   = {chunk_reg, lane};

    assign stat.done = run_reg && (any_hit || last_chunk);
    assign stat.hit  = run_reg && any_hit;
    assign index     = IDX_W'(idx_wide);

    always_comb begin
        vec_next   = vec_reg;
        chunk_next = chunk_reg;
        run_next   = run_reg;
        if (start) begin
            vec_next              = '0;
            vec_next[DEPTH-1:0]   = match_in;
            chunk_next            = '0;
            run_next              = 1'b1;
        end else if (stat.done) begin
            run_next = 1'b0;
        end else if (run_reg) begin
            chunk_next = chunk_reg + CH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            chunk_reg <= '0;
        end else begin
            run_reg   <= run_next;
            chunk_reg <= chunk_next;
        end
        vec_reg <= vec_next;
    end

endmodule

@@ rtl/positional_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH items with read, find, insert and remove.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries action, position and item_in.
//   Result channel m_valid/m_ready carries ok, item_out, found_at, count_out,
//   one result item per input item, in order.
//   s_ready is high while the engine is idle; the list itself is updated at
//   the accepting edge by the row of cells (parallel shift up or down).
//   Read, insert and remove: the result is registered at acceptance and
//   moved to the output register from the done state. Find: the match
//   vector is captured at acceptance and scanned 8 cells a cycle, over 1
//   to ceil(DEPTH/8) groups, until the first hit or the last group. A new
//   item waits until the previous result leaves the done state. The output
//   register lets a new item be accepted while the previous result still
//   waits; a stalled receiver holds the next result in the engine and keeps
//   s_ready low until that result moves out.
//   Reset empties the list (count 0) and drops any pending result.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int DEPTH      = ple_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = ple_pkg::ITEM_WIDTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int IDX_W = $clog2(DEPTH),
    localparam int FA_W  = IDX_W + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_action,
    input  logic [CNT_W-1:0]       s_position,
    input  logic [ITEM_WIDTH-1:0]  s_item_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_ok,
    output logic [ITEM_WIDTH-1:0]  m_item_out,
    output logic signed [FA_W-1:0] m_found_at,
    output logic [CNT_W-1:0]       m_count_out
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    res_ok_reg, res_ok_next;
    logic [ITEM_WIDTH-1:0]   res_item_reg, res_item_next;
    logic [FA_W-1:0]         res_found_reg, res_found_next;
    logic [CNT_W-1:0]        res_count_reg, res_count_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_ok_reg, m_ok_next;
    logic [ITEM_WIDTH-1:0]   m_item_reg, m_item_next;
    logic [FA_W-1:0]         m_found_reg, m_found_next;
    logic [CNT_W-1:0]        m_count_reg, m_count_next;

    logic                    accept;
    ple_pkg::action_t        action;
    logic                    rd_ok;
    logic                    ins_ok;
    logic                    rem_ok;
    logic                    ins_fire;
    logic                    rem_fire;
    logic [ITEM_WIDTH-1:0]   rd_data;

    logic [ITEM_WIDTH-1:0]   cell_item [DEPTH];
    logic [DEPTH-1:0]        cell_match;
    logic [DEPTH-1:0]        match_vec;
    ple_pkg::cell_op_t       cell_op [DEPTH];

    ple_pkg::scan_stat_t     scan_stat;
    logic [IDX_W-1:0]        scan_index;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign action   = ple_pkg::action_t'(s_action);
    assign rd_ok    = (s_position < count_reg);
    assign rem_ok   = rd_ok;
    assign ins_ok   = (s_position <= count_reg) && (count_reg != CNT_W'(DEPTH));
    assign ins_fire = accept && (action == ple_pkg::ACT_INSERT) && ins_ok;
    assign rem_fire = accept && (action == ple_pkg::ACT_REMOVE) && rem_ok;
    assign rd_data  = cell_item[s_position[IDX_W-1:0]];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDXV = CNT_W'(i);
        logic [ITEM_WIDTH-1:0] left_item;
        logic [ITEM_WIDTH-1:0] right_item;

        if (i == 0) begin : g_first
            assign left_item = '0;
        end else begin : g_mid_l
            assign left_item = cell_item[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_item = '0;
        end else begin : g_mid_r
            assign right_item = cell_item[i+1];
        end

        always_comb begin
            cell_op[i] = ple_pkg::CELL_HOLD;
            if (ins_fire && (IDXV == s_position)) begin
                cell_op[i] = ple_pkg::CELL_LOAD;
            end else if (ins_fire && (IDXV > s_position)) begin
                cell_op[i] = ple_pkg::CELL_SHIFT_UP;
            end else if (rem_fire && (IDXV >= s_position)) begin
                cell_op[i] = ple_pkg::CELL_SHIFT_DOWN;
            end
        end

        assign match_vec[i] = cell_match[i] && (IDXV < count_reg);

        ple_cell #(
            .ITEM_WIDTH (ITEM_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .op         (cell_op[i]),
            .item_in    (s_item_in),
            .left_item  (left_item),
            .right_item (right_item),
            .key        (s_item_in),
            .item_q     (cell_item[i]),
            .match      (cell_match[i])
        );
    end

    ple_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && (action == ple_pkg::ACT_FIND)),
        .match_in (match_vec),
        .stat     (scan_stat),
        .index    (scan_index)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_ok_next    = res_ok_reg;
        res_item_next  = res_item_reg;
        res_found_next = res_found_reg;
        res_count_next = res_count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_ok_next      = m_ok_reg;
        m_item_next    = m_item_reg;
        m_found_next   = m_found_reg;
        m_count_next   = m_count_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_item_next  = '0;
                    res_found_next = '1;
                    state_next     = ST_DONE;
                    unique case (action)
                        ple_pkg::ACT_READ: begin
                            res_ok_next   = rd_ok;
                            res_item_next = rd_ok ? rd_data : '0;
                        end
                        ple_pkg::ACT_FIND: begin
                            res_ok_next = 1'b0;
                            state_next  = ST_SCAN;
                        end
                        ple_pkg::ACT_INSERT: begin
                            res_ok_next = ins_ok;
                            if (ins_ok) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ple_pkg::ACT_REMOVE: begin
                            res_ok_next = rem_ok;
                            if (rem_ok) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default: begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                    res_count_next = count_next;
                end
            end
            ST_SCAN: begin
                if (scan_stat.done) begin
                    res_ok_next    = scan_stat.hit;
                    res_found_next = scan_stat.hit ? {1'b0, scan_index} : '1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_item_next  = res_item_reg;
                    m_found_next = res_found_reg;
                    m_count_next = res_count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        res_ok_reg    <= res_ok_next;
        res_item_reg  <= res_item_next;
        res_found_reg <= res_found_next;
        res_count_reg <= res_count_next;
        m_ok_reg      <= m_ok_next;
        m_item_reg    <= m_item_next;
        m_found_reg   <= m_found_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_ok        = m_ok_reg;
    assign m_item_out  = m_item_reg;
    assign m_found_at  = m_found_reg;
    assign m_count_out = m_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count above depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_fire |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_scan_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_stat.done |-> state_reg == ST_SCAN)
        else $error("scan finished outside the scan state");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found_at[FA_W-1]) |-> m_ok)
        else $error("found position reported without ok");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine. A scoreboard keeps its
// own copy of the list, works out the reply of every accepted command and
// compares each reply field by field, in order. Directed commands cover the
// empty and full list, range failures and the extreme values. Random traffic
// alternates between growing and shrinking the list. Both handshakes idle at
// random, with one calm stretch.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIST_DEPTH = ple_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        logic              ok;
        logic [31:0]       item_out;
        logic signed [4:0] found_at;
        logic [4:0]        count_out;
    } list_reply_t;

    class list_scoreboard;
        logic [31:0] slots [LIST_DEPTH];
        int          count;
        list_reply_t replies_due [$];
        int          errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        function void note_command(ple_pkg::action_t act, logic [4:0] pos,
                                   logic [31:0] item);
            list_reply_t r;
            bit          hit;
            r.ok = 1'b0;
            r.item_out = '0;
            r.found_at = 5'h1F;
            hit = 1'b0;
            case (act)
                ple_pkg::ACT_READ: begin
                    if (pos < count) begin
                        r.ok = 1'b1;
                        r.item_out = slots[pos];
                    end
                end
                ple_pkg::ACT_FIND: begin
                    for (int i = 0; i < count; i++) begin
                        if (!hit && slots[i] == item) begin
                            hit = 1'b1;
                            r.ok = 1'b1;
                            r.found_at = 5'(i);
                        end
                    end
                end
                ple_pkg::ACT_INSERT: begin
                    if (pos <= count && count < LIST_DEPTH) begin
                        for (int i = count; i > pos; i--) begin
                            slots[i] = slots[i - 1];
                        end
                        slots[pos] = item;
                        count++;
                        r.ok = 1'b1;
                    end
                end
                default: begin
                    if (pos < count) begin
                        for (int i = pos; i + 1 < count; i++) begin
                            slots[i] = slots[i + 1];
                        end
                        count--;
                        r.ok = 1'b1;
                    end
                end
            endcase
            r.count_out = 5'(count);
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic ok, logic [31:0] item_out,
                                  logic signed [4:0] found_at, logic [4:0] count_out);
            list_reply_t r;
            if (replies_due.size() == 0) begin
                $error("unexpected result item");
                errors++;
                return;
            end
            r = replies_due.pop_front();
            if (ok !== r.ok) begin
                $error("ok: expected %0b, actual %0b", r.ok, ok);
                errors++;
            end
            if (item_out !== r.item_out) begin
                $error("item_out: expected %h, actual %h", r.item_out, item_out);
                errors++;
            end
            if (found_at !== r.found_at) begin
                $error("found_at: expected %0d, actual %0d", r.found_at, found_at);
                errors++;
            end
            if (count_out !== r.count_out) begin
                $error("count_out: expected %0d, actual %0d", r.count_out, count_out);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_action;
    logic [4:0]        s_position;
    logic [31:0]       s_item_in;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_ok;
    logic [31:0]       m_item_out;
    logic signed [4:0] m_found_at;
    logic [4:0]        m_count_out;

    bit                calm = 1'b0;
    list_scoreboard    sb;

    positional_list_engine u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_position (s_position),
        .s_item_in  (s_item_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_ok       (m_ok),
        .m_item_out (m_item_out),
        .m_found_at (m_found_at),
        .m_count_out(m_count_out)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_reply(m_ok, m_item_out, m_found_at, m_count_out);
        end
    end

    // Enter and leave at a falling edge; valid stays high on return.
    task automatic send_command(ple_pkg::action_t act, logic [4:0] pos, logic [31:0] item);
        while (!calm && $urandom_range(0, 99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_position <= pos;
        s_item_in  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_command(act, pos, item);
        @(negedge aclk);
    endtask

    task automatic random_command(bit grow);
        ple_pkg::action_t act;
        logic [4:0]       pos;
        logic [31:0]      item;
        int               n;
        n = sb.count;
        if ($urandom_range(0, 99) < 30) begin
            act = grow ? ple_pkg::ACT_INSERT : ple_pkg::ACT_REMOVE;
        end else begin
            act = ple_pkg::action_t'($urandom_range(0, 3));
        end
        item = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
        if ($urandom_range(0, 99) < 15) begin
            pos = 5'($urandom_range(0, 31));
        end else begin
            case (act)
                ple_pkg::ACT_INSERT: pos = 5'($urandom_range(0, n));
                ple_pkg::ACT_READ, ple_pkg::ACT_REMOVE:
                    pos = (n == 0) ? 5'd0 : 5'($urandom_range(0, n - 1));
                default: pos = 5'($urandom_range(0, 31));
            endcase
        end
        if (act == ple_pkg::ACT_FIND && n > 0 && $urandom_range(0, 1) == 1) begin
            item = sb.slots[$urandom_range(0, n - 1)];
        end
        send_command(act, pos, item);
    endtask

    initial begin
        s_valid    = 1'b0;
        s_action   = ple_pkg::ACT_READ;
        s_position = '0;
        s_item_in  = '0;
        aresetn    = 1'b0;
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list and range failures
        send_command(ple_pkg::ACT_READ, 5'd0, 32'h0);
        send_command(ple_pkg::ACT_FIND, 5'd0, 32'h0);
        send_command(ple_pkg::ACT_REMOVE, 5'd0, 32'h0);
        send_command(ple_pkg::ACT_INSERT, 5'd1, 32'h0);
        send_command(ple_pkg::ACT_INSERT, 5'd0, 32'h0);
        send_command(ple_pkg::ACT_INSERT, 5'd1, 32'hFFFF_FFFF);
        send_command(ple_pkg::ACT_FIND, 5'd31, 32'hFFFF_FFFF);
        send_command(ple_pkg::ACT_FIND, 5'd0, 32'h1234_5678);
        send_command(ple_pkg::ACT_READ, 5'd31, 32'hFFFF_FFFF);
        send_command(ple_pkg::ACT_INSERT, 5'd31, 32'hA5A5_A5A5);
        send_command(ple_pkg::ACT_REMOVE, 5'd2, 32'h0);

        // fill, then hit the full list
        while (sb.count < LIST_DEPTH) begin
            send_command(ple_pkg::ACT_INSERT, 5'($urandom_range(0, sb.count)), $urandom);
        end
        send_command(ple_pkg::ACT_INSERT, 5'd0, 32'h5A5A_5A5A);
        send_command(ple_pkg::ACT_FIND, 5'd0, sb.slots[LIST_DEPTH - 1]);
        send_command(ple_pkg::ACT_READ, 5'(LIST_DEPTH - 1), 32'h0);
        send_command(ple_pkg::ACT_REMOVE, 5'(LIST_DEPTH - 1), 32'h0);
        send_command(ple_pkg::ACT_REMOVE, 5'd0, 32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 150 && i < 250);
            random_command(((i / 40) % 2) == 0);
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (sb.replies_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
